FILE: hdl/dpod_pkg.sv
package dpod_pkg;

	// Field types of one query and one result.
	typedef logic [4:0]  day_t;
	typedef logic [3:0]  month_t;
	typedef logic [13:0] year_t;
	typedef logic [21:0] overlap_t;

	// Linear day number of one date, year 0 January 1 being day 1.
	typedef logic [22:0] day_num_t;

	// Offset of a month's first day within its year.
	typedef logic [8:0] month_off_t;

	// Quotient of a year by 100.
	typedef logic [7:0] cent_t;

	localparam int unsigned DAYS_PER_YEAR = 365;

	// Year / 100 as (year * 5243) >> 19, exact for every 14-bit year.
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned DIV100_PROD_W = 27;

	localparam overlap_t OVERLAP_MAX = '1;

	// Stage enables of one conversion lane.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

	// Stage enables of the merging stage.
	typedef struct packed {
		logic en_s4;
		logic en_s5;
	} merge_ctl_t;

	// Days before the first of a month; month 0 reads as January and
	// months beyond twelve read as December.
	function automatic month_off_t days_before_month(input month_t m);
		month_off_t off;
		unique case (m)
			4'd0, 4'd1: off = 9'd0;
			4'd2:       off = 9'd31;
			4'd3:       off = 9'd59;
			4'd4:       off = 9'd90;
			4'd5:       off = 9'd120;
			4'd6:       off = 9'd151;
			4'd7:       off = 9'd181;
			4'd8:       off = 9'd212;
			4'd9:       off = 9'd243;
			4'd10:      off = 9'd273;
			4'd11:      off = 9'd304;
			default:    off = 9'd334;
		endcase
		return off;
	endfunction

endpackage

FILE: hdl/dpod_if.sv
// Query channel: two periods of two dates each.
interface dpod_query_if import dpod_pkg::*; ();
	logic   valid;
	logic   ready;
	day_t   first_start_day;
	month_t first_start_month;
	year_t  first_start_year;
	day_t   first_end_day;
	month_t first_end_month;
	year_t  first_end_year;
	day_t   second_start_day;
	month_t second_start_month;
	year_t  second_start_year;
	day_t   second_end_day;
	month_t second_end_month;
	year_t  second_end_year;

	modport source (
		output valid,
		input  ready,
		output first_start_day, first_start_month, first_start_year,
		output first_end_day, first_end_month, first_end_year,
		output second_start_day, second_start_month, second_start_year,
		output second_end_day, second_end_month, second_end_year
	);

	modport sink (
		input  valid,
		output ready,
		input  first_start_day, first_start_month, first_start_year,
		input  first_end_day, first_end_month, first_end_year,
		input  second_start_day, second_start_month, second_start_year,
		input  second_end_day, second_end_month, second_end_year
	);
endinterface

// Result channel: the number of shared days.
interface dpod_result_if import dpod_pkg::*; ();
	logic     valid;
	logic     ready;
	overlap_t overlap_days;

	modport source (output valid, input ready, output overlap_days);
	modport sink (input valid, output ready, input overlap_days);
endinterface

FILE: hdl/date_period_overlap_days.sv
// Pipeline: a query passes lane stages 1 to 3, then merge stage 4 and stage 5, the output register.
// Throughput: one transaction per cycle while the output is not stalled; four date lanes convert in parallel.
// Each stage advances whenever it is empty or its successor advances, so a
// query is taken while a finished result still waits, as long as a bubble exists.
// Reset (arst_n low, asynchronous) clears the stage valid flags; data is not reset.
module date_period_overlap_days import dpod_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	dpod_query_if.sink query,
	dpod_result_if.source result
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	lane_ctl_t  lane_ctl;
	merge_ctl_t merge_ctl;

	day_num_t fs_num, fe_num, ss_num, se_num;

	// Stage enables: a stage loads when it is empty or drains forward.
	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign query.ready = en_s1;

	assign lane_ctl  = '{en_s1: en_s1, en_s2: en_s2, en_s3: en_s3};
	assign merge_ctl = '{en_s4: en_s4, en_s5: en_s5};

	// Valid flags of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= query.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Four conversion lanes, one per date.
	dpod_day_lane u_lane_fs (
		.clk     (clk),
		.ctl     (lane_ctl),
		.day     (query.first_start_day),
		.month   (query.first_start_month),
		.year    (query.first_start_year),
		.day_num (fs_num)
	);

	dpod_day_lane u_lane_fe (
		.clk     (clk),
		.ctl     (lane_ctl),
		.day     (query.first_end_day),
		.month   (query.first_end_month),
		.year    (query.first_end_year),
		.day_num (fe_num)
	);

	dpod_day_lane u_lane_ss (
		.clk     (clk),
		.ctl     (lane_ctl),
		.day     (query.second_start_day),
		.month   (query.second_start_month),
		.year    (query.second_start_year),
		.day_num (ss_num)
	);

	dpod_day_lane u_lane_se (
		.clk     (clk),
		.ctl     (lane_ctl),
		.day     (query.second_end_day),
		.month   (query.second_end_month),
		.year    (query.second_end_year),
		.day_num (se_num)
	);

	// Merge of the lane results into the output register.
	dpod_merge u_merge (
		.clk          (clk),
		.ctl          (merge_ctl),
		.first_start  (fs_num),
		.first_end    (fe_num),
		.second_start (ss_num),
		.second_end   (se_num),
		.overlap      (result.overlap_days)
	);

	assign result.valid = v_s5;

	// An empty first stage never blocks a query.
	a_bubble_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> query.ready)
		else $error("first stage empty but query not accepted");

	// An accepted query occupies the first stage next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> v_s1)
		else $error("accepted query lost at stage 1");

	// A transaction leaving stage 4 lands in the output register.
	a_merge_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s4) |=> v_s5)
		else $error("transaction lost between stage 4 and stage 5");

	// A full pipeline with a stalled output takes no query.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !result.ready) |-> !query.ready)
		else $error("query accepted into a full stalled pipeline");

endmodule

FILE: hdl/dpod_day_lane.sv
// One date to linear day number, three pipeline stages.
module dpod_day_lane import dpod_pkg::*; (
	input  logic      clk,
	input  lane_ctl_t ctl,
	input  day_t      day,
	input  month_t    month,
	input  year_t     year,
	output day_num_t  day_num
);

	logic [DIV100_PROD_W-1:0] q_prod;

	day_num_t   prod365_s1;
	cent_t      q100_s1;
	year_t      year_s1;
	month_off_t moff_s1;
	logic       after_feb_s1;
	day_t       day_s1;

	logic [14:0] rem_full;
	logic        rem_nz;
	logic [14:0] year_p3;
	logic [12:0] quarter;
	logic        leap;

	day_num_t    base_s2;
	logic [8:0]  c100_s2;
	logic [6:0]  c400_s2;
	day_num_t    day_num_s3;

	// Stage 1: the two multiplications and the month table.
	assign q_prod = DIV100_PROD_W'(year) * DIV100_PROD_W'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod365_s1   <= day_num_t'(year) * day_num_t'(DAYS_PER_YEAR);
			q100_s1      <= q_prod[DIV100_SHIFT +: $bits(cent_t)];
			year_s1      <= year;
			moff_s1      <= days_before_month(month);
			after_feb_s1 <= (month > 4'd2);
			day_s1       <= day;
		end
	end

	// Stage 2: remainder by 100, leap flag and the positive terms.
	always_comb begin
		rem_full = 15'(year_s1) - 15'(q100_s1) * 15'd100;
		rem_nz   = (rem_full[6:0] != 7'd0);
		year_p3  = 15'(year_s1) + 15'd3;
		quarter  = year_p3[14:2];
		leap     = rem_nz ? (year_s1[1:0] == 2'd0) : (q100_s1[1:0] == 2'd0);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			base_s2 <= prod365_s1 + day_num_t'(quarter) + day_num_t'(moff_s1)
				+ day_num_t'(day_s1) + day_num_t'(after_feb_s1 & leap);
			c100_s2 <= 9'(q100_s1) + 9'(rem_nz);
			c400_s2 <= 7'(q100_s1[7:2])
				+ 7'(rem_nz | (q100_s1[1:0] != 2'd0));
		end
	end

	// Stage 3: century corrections.
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			day_num_s3 <= base_s2 - day_num_t'(c100_s2) + day_num_t'(c400_s2);
		end
	end

	assign day_num = day_num_s3;

endmodule

FILE: hdl/dpod_merge.sv
// Combines the four day numbers into the clamped overlap count.
module dpod_merge import dpod_pkg::*; (
	input  logic       clk,
	input  merge_ctl_t ctl,
	input  day_num_t   first_start,
	input  day_num_t   first_end,
	input  day_num_t   second_start,
	input  day_num_t   second_end,
	output overlap_t   overlap
);

	day_num_t    lo_s4;
	day_num_t    hi_s4;
	logic [23:0] span;
	overlap_t    overlap_s5;

	// Stage 4: latest start and earliest end.
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			lo_s4 <= (first_start > second_start) ? first_start : second_start;
			hi_s4 <= (first_end < second_end) ? first_end : second_end;
		end
	end

	// Stage 5: inclusive span, zero when empty, saturated at the field top.
	assign span = 24'(hi_s4) - 24'(lo_s4) + 24'd1;

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			priority if (hi_s4 < lo_s4) begin
				overlap_s5 <= '0;
			end else if (span[23:22] != 2'd0) begin
				overlap_s5 <= OVERLAP_MAX;
			end else begin
				overlap_s5 <= span[21:0];
			end
		end
	end

	assign overlap = overlap_s5;

endmodule
